[rtl/zpu_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package zpu_pkg;

    localparam int N_W       = 5;
    localparam int RANK_W    = 63;
    localparam int CNT_W     = 64;
    localparam int DEF_MAX_N = 20;

    // Pass direction while the count table is being built.
    localparam logic DIR_DOWN = 1'b0;
    localparam logic DIR_UP   = 1'b1;

    typedef enum logic [2:0] {
        ST_FILL_INIT,
        ST_FILL_RD,
        ST_FILL_ACC,
        ST_IDLE,
        ST_SCAN,
        ST_EVAL,
        ST_EMIT,
        ST_ERR
    } t_state;

endpackage

`default_nettype wire

[rtl/zigzag_permutation_unrank_top.sv]
`timescale 1ns / 1ps
`default_nettype none

// Reset fills the tail count table row by row; no item is taken until it ends. Each
// item is then walked one position at a time: the candidate scan steps past used
// candidates and does one table read and one add per unused candidate, and the
// finished item leaves as n output beats. An error is found at once or during the
// scan and gives one beat. Items are served one at a time; the next is taken while
// the last beat still waits.
module zigzag_permutation_unrank_top #(
    parameter int MAX_N = zpu_pkg::DEF_MAX_N
) (
    input  wire                      i_clk,
    input  wire                      i_rst_n,
    input  wire                      i_in_valid,
    output logic                     o_in_ready,
    input  wire [zpu_pkg::N_W-1:0]   i_fence_size,
    input  wire [zpu_pkg::RANK_W-1:0] i_rank,
    output logic                     o_out_valid,
    input  wire                      i_out_ready,
    output logic [zpu_pkg::N_W-1:0]  o_element_value,
    output logic                     o_last,
    output logic                     o_rank_error
);
    import zpu_pkg::*;

    localparam int DEPTH = MAX_N * MAX_N;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int VW    = (MAX_N > 1) ? $clog2(MAX_N) : 1;
    localparam logic [AW-1:0]  ROW_STEP = AW'(MAX_N);
    localparam logic [N_W-1:0] N_MAX    = N_W'(MAX_N);

    // Tail counts, one memory per step direction, indexed by row (length - 1) and ordinal.
    logic [CNT_W-1:0] down_mem [DEPTH];
    logic [CNT_W-1:0] up_mem   [DEPTH];
    logic [CNT_W-1:0] r_down_q, r_up_q;

    t_state           r_state, n_state;
    logic [N_W-1:0]   r_len, n_len;
    logic [N_W-1:0]   r_a, n_a;
    logic             r_dir, n_dir;
    logic [CNT_W-1:0] r_acc, n_acc;
    logic [AW-1:0]    r_row, n_row;

    logic [N_W-1:0]    r_n, n_n;
    logic [RANK_W-1:0] r_rank, n_rank;
    logic [N_W-1:0]    r_pos, n_pos;
    logic [N_W-1:0]    r_cand, n_cand;
    logic [N_W-1:0]    r_ord, n_ord;
    logic [N_W-1:0]    r_prev, n_prev;
    logic [N_W-1:0]    r_pprev, n_pprev;
    logic [CNT_W-1:0]  r_skip, n_skip;
    logic [MAX_N-1:0]  r_used, n_used;
    logic [N_W-1:0]    r_out_idx, n_out_idx;
    logic [N_W-1:0]    r_values [MAX_N];

    logic             r_out_valid, n_out_valid;
    logic [N_W-1:0]   r_out_value, n_out_value;
    logic             r_out_last, n_out_last;
    logic             r_out_err, n_out_err;

    logic             we_down, we_up, val_we;
    logic [AW-1:0]    w_addr, rd_addr;
    logic [CNT_W-1:0] w_data;
    logic [CNT_W-1:0] add_a, add_b, add_sum;
    logic [CNT_W-1:0] term;
    logic [N_W-1:0]   cand_m1, pos_m1, rem;
    logic             hit, slot_free, last_beat;

    assign cand_m1   = r_cand - N_W'(1);
    assign pos_m1    = r_pos - N_W'(1);
    assign rem       = r_n - r_pos + N_W'(1);
    assign slot_free = !r_out_valid || i_out_ready;
    assign last_beat = (r_out_idx == r_n - N_W'(1));

    // Step term for the current candidate; the first position may start either way.
    always_comb begin
        priority if (r_pos == N_W'(1)) begin
            term = r_up_q + r_down_q;
        end else if (r_cand > r_prev && (r_pos <= N_W'(2) || r_pprev > r_prev)) begin
            term = r_down_q;
        end else if (r_cand < r_prev && (r_pos <= N_W'(2) || r_pprev < r_prev)) begin
            term = r_up_q;
        end else begin
            term = '0;
        end
    end

    // The one shared adder: table accumulation at fill time, running rank sum in the walk.
    always_comb begin
        if (r_state == ST_EVAL) begin
            add_a = r_skip;
            add_b = term;
        end else begin
            add_a = r_acc;
            add_b = (r_dir == DIR_UP) ? r_down_q : r_up_q;
        end
    end
    assign add_sum = add_a + add_b;
    assign hit     = (add_sum >= {1'b0, r_rank});

    always_comb begin
        n_state     = r_state;
        n_len       = r_len;
        n_a         = r_a;
        n_dir       = r_dir;
        n_acc       = r_acc;
        n_row       = r_row;
        n_n         = r_n;
        n_rank      = r_rank;
        n_pos       = r_pos;
        n_cand      = r_cand;
        n_ord       = r_ord;
        n_prev      = r_prev;
        n_pprev     = r_pprev;
        n_skip      = r_skip;
        n_used      = r_used;
        n_out_idx   = r_out_idx;
        n_out_valid = r_out_valid && !i_out_ready;
        n_out_value = r_out_value;
        n_out_last  = r_out_last;
        n_out_err   = r_out_err;
        we_down     = 1'b0;
        we_up       = 1'b0;
        val_we      = 1'b0;
        w_addr      = r_row + AW'(r_a) - AW'(1);
        w_data      = r_acc;
        rd_addr     = r_row + AW'(r_ord);
        o_in_ready  = 1'b0;

        unique case (r_state)
            ST_FILL_INIT: begin
                we_down = 1'b1;
                we_up   = 1'b1;
                w_addr  = '0;
                w_data  = CNT_W'(1);
                if (MAX_N == 1) begin
                    n_state = ST_IDLE;
                end else begin
                    n_len   = N_W'(2);
                    n_row   = ROW_STEP;
                    n_a     = N_W'(1);
                    n_dir   = DIR_DOWN;
                    n_acc   = '0;
                    n_state = ST_FILL_RD;
                end
            end
            ST_FILL_RD: begin
                if (r_dir == DIR_DOWN) begin
                    we_down = 1'b1;
                    rd_addr = r_row - ROW_STEP + AW'(r_a) - AW'(1);
                    if (r_a == r_len) begin
                        n_dir = DIR_UP;
                        n_acc = '0;
                    end else begin
                        n_state = ST_FILL_ACC;
                    end
                end else begin
                    we_up   = 1'b1;
                    rd_addr = r_row - ROW_STEP + AW'(r_a) - AW'(2);
                    if (r_a == N_W'(1)) begin
                        if (r_len == N_MAX) begin
                            n_state = ST_IDLE;
                        end else begin
                            n_len = r_len + N_W'(1);
                            n_row = r_row + ROW_STEP;
                            n_dir = DIR_DOWN;
                            n_acc = '0;
                        end
                    end else begin
                        n_state = ST_FILL_ACC;
                    end
                end
            end
            ST_FILL_ACC: begin
                n_acc   = add_sum;
                n_a     = (r_dir == DIR_UP) ? r_a - N_W'(1) : r_a + N_W'(1);
                n_state = ST_FILL_RD;
            end
            ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    n_n     = i_fence_size;
                    n_rank  = i_rank;
                    n_pos   = N_W'(1);
                    n_cand  = N_W'(1);
                    n_ord   = '0;
                    n_prev  = '0;
                    n_pprev = '0;
                    n_skip  = '0;
                    n_used  = '0;
                    n_row   = AW'(i_fence_size - N_W'(1)) * ROW_STEP;
                    if (i_fence_size == '0 || i_fence_size > N_MAX || i_rank == '0) begin
                        n_state = ST_ERR;
                    end else begin
                        n_state = ST_SCAN;
                    end
                end
            end
            ST_SCAN: begin
                // Used candidates are skipped here; an unused one goes on to a table read.
                if (r_cand > r_n) begin
                    n_state = ST_ERR;
                end else if (r_used[cand_m1[VW-1:0]]) begin
                    n_cand = r_cand + N_W'(1);
                end else if (r_ord >= rem) begin
                    n_state = ST_ERR;
                end else begin
                    n_state = ST_EVAL;
                end
            end
            ST_EVAL: begin
                if (hit) begin
                    val_we                 = 1'b1;
                    n_used                 = r_used | (MAX_N'(1) << cand_m1[VW-1:0]);
                    n_pprev                = r_prev;
                    n_prev                 = r_cand;
                    if (r_pos == r_n) begin
                        n_out_idx = '0;
                        n_state   = ST_EMIT;
                    end else begin
                        n_pos   = r_pos + N_W'(1);
                        n_cand  = N_W'(1);
                        n_ord   = '0;
                        n_row   = r_row - ROW_STEP;
                        n_state = ST_SCAN;
                    end
                end else begin
                    n_skip  = add_sum;
                    n_ord   = r_ord + N_W'(1);
                    n_cand  = r_cand + N_W'(1);
                    n_state = ST_SCAN;
                end
            end
            ST_EMIT: begin
                if (slot_free) begin
                    n_out_valid = 1'b1;
                    n_out_value = r_values[r_out_idx[VW-1:0]];
                    n_out_last  = last_beat;
                    n_out_err   = 1'b0;
                    n_out_idx   = r_out_idx + N_W'(1);
                    if (last_beat) begin
                        n_state = ST_IDLE;
                    end
                end
            end
            ST_ERR: begin
                if (slot_free) begin
                    n_out_valid = 1'b1;
                    n_out_value = '0;
                    n_out_last  = 1'b1;
                    n_out_err   = 1'b1;
                    n_state     = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (we_down) begin
            down_mem[w_addr] <= w_data;
        end
        r_down_q <= down_mem[rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (we_up) begin
            up_mem[w_addr] <= w_data;
        end
        r_up_q <= up_mem[rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (val_we) begin
            r_values[pos_m1[VW-1:0]] <= r_cand;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_FILL_INIT;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_len       <= n_len;
        r_a         <= n_a;
        r_dir       <= n_dir;
        r_acc       <= n_acc;
        r_row       <= n_row;
        r_n         <= n_n;
        r_rank      <= n_rank;
        r_pos       <= n_pos;
        r_cand      <= n_cand;
        r_ord       <= n_ord;
        r_prev      <= n_prev;
        r_pprev     <= n_pprev;
        r_skip      <= n_skip;
        r_used      <= n_used;
        r_out_idx   <= n_out_idx;
        r_out_value <= n_out_value;
        r_out_last  <= n_out_last;
        r_out_err   <= n_out_err;
    end

    assign o_out_valid     = r_out_valid;
    assign o_element_value = r_out_value;
    assign o_last          = r_out_last;
    assign o_rank_error    = r_out_err;

endmodule

`default_nettype wire
